// ===== rtl/core/rsd_pkg.sv =====
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared widths, constants, item type and the square root step for the
// radial stick deadzone unit.
// ----------------------------------------------------------------------------
package rsd_pkg;

	// full deflection of the rescaled stick, in stick units
	localparam int FULL_SCALE = 10000;

	localparam int AXIS_W     = 15;
	localparam int DZ_W       = 14;
	localparam int DZ_RESET   = 1000;
	localparam int DATA_W     = 32;

	// magnitude carries 8 fraction bits: radicand is the square sum times 2^16
	localparam int FRAC_SH    = 16;
	localparam int SUMSQ_W    = 2 * AXIS_W;
	localparam int RAD_W      = SUMSQ_W + FRAC_SH;
	localparam int MAG_W      = RAD_W / 2;
	localparam int SQR_W      = MAG_W + 2;

	// remap divider: (mag - dz*256) * FULL_SCALE / (FULL_SCALE - dz)
	localparam int FULL_W     = $clog2(FULL_SCALE + 1);
	localparam int NEWMAG_MAX = FULL_SCALE * 256;
	localparam int NM_W       = $clog2(NEWMAG_MAX + 1);
	localparam int NUM_W      = MAG_W + FULL_W;

	// axis divider: |axis| * newmag / mag
	localparam int PROD_W     = AXIS_W + NM_W;
	localparam int AX_QW      = AXIS_W;
	localparam int NEG_LIM    = 2 ** (AXIS_W - 1);
	localparam int POS_LIM    = 2 ** (AXIS_W - 1) - 1;

	typedef struct packed {
		logic signed [AXIS_W-1:0] x;
		logic signed [AXIS_W-1:0] y;
		logic [AXIS_W-1:0]        ux;
		logic [AXIS_W-1:0]        uy;
		logic [SUMSQ_W-1:0]       sumsq;
		logic                     bypass;
	} item_t;

	typedef struct packed {
		logic [SQR_W-1:0] rem;
		logic [MAG_W-1:0] root;
	} sq_t;

	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic             indz;
		logic             sat;
		logic             ovf;
		logic [NM_W-1:0]  newmag;
	} late_t;

	// one digit of the restoring square root: bring in two radicand bits
	function automatic sq_t sqrt_step(input sq_t prev, input logic [1:0] bits);
		logic [SQR_W+1:0] cur;
		logic [SQR_W+1:0] trial;
		sq_t              res;
		cur   = {prev.rem, bits};
		trial = (SQR_W + 2)'({prev.root, 2'b01});
		if (cur >= trial) begin
			res.rem  = SQR_W'(cur - trial);
			res.root = {prev.root[MAG_W-2:0], 1'b1};
		end else begin
			res.rem  = SQR_W'(cur);
			res.root = {prev.root[MAG_W-2:0], 1'b0};
		end
		return res;
	endfunction

endpackage

// ===== rtl/core/rsd_front.sv =====
// ----------------------------------------------------------------------------
// rsd_front
// Accepts stick samples, takes absolute values, forms the square sum and
// marks bypass samples, then pushes the item into the queue.
// ----------------------------------------------------------------------------
module rsd_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [rsd_pkg::DATA_W-1:0]   s_axis_tdata,
	input  logic [rsd_pkg::DZ_W-1:0]     deadzone,
	input  logic                         q_full,
	output logic                         q_push,
	output rsd_pkg::item_t               q_item
);

	logic                                 v_s1, v_s2, en_s1, en_s2;
	logic signed [rsd_pkg::AXIS_W-1:0]    x_in, y_in, x_s1, y_s1;
	logic [rsd_pkg::AXIS_W-1:0]           ux_in, uy_in, ux_s1, uy_s1;
	rsd_pkg::item_t                       item_s2;

	// stage enables: advance when the next place is free
	assign en_s2         = !v_s2 || !q_full;
	assign en_s1         = !v_s1 || en_s2;
	assign s_axis_tready = en_s1;

	assign x_in  = s_axis_tdata[rsd_pkg::AXIS_W-1:0];
	assign y_in  = s_axis_tdata[2*rsd_pkg::AXIS_W-1:rsd_pkg::AXIS_W];
	assign ux_in = x_in[rsd_pkg::AXIS_W-1] ? (~x_in + 1'b1) : x_in;
	assign uy_in = y_in[rsd_pkg::AXIS_W-1] ? (~y_in + 1'b1) : y_in;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_axis_tvalid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	// capture the beat and its absolute values
	always_ff @(posedge clk) begin
		if (en_s1) begin
			x_s1  <= x_in;
			y_s1  <= y_in;
			ux_s1 <= ux_in;
			uy_s1 <= uy_in;
		end
	end

	// square sum and bypass flag
	always_ff @(posedge clk) begin
		if (en_s2) begin
			item_s2.x      <= x_s1;
			item_s2.y      <= y_s1;
			item_s2.ux     <= ux_s1;
			item_s2.uy     <= uy_s1;
			item_s2.sumsq  <= rsd_pkg::SUMSQ_W'(ux_s1) * rsd_pkg::SUMSQ_W'(ux_s1)
			                + rsd_pkg::SUMSQ_W'(uy_s1) * rsd_pkg::SUMSQ_W'(uy_s1);
			item_s2.bypass <= (deadzone == '0);
		end
	end

	assign q_push = v_s2 && !q_full;
	assign q_item = item_s2;

endmodule

// ===== rtl/core/rsd_queue.sv =====
// ----------------------------------------------------------------------------
// rsd_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module rsd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rsd_pkg::item_t wr_item,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output rsd_pkg::item_t rd_item
);

	rsd_pkg::item_t mem_q [2];
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign rd_item   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_item;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop)
		else $error("queue pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n) count_q != 2'd3)
		else $error("queue count out of range");

endmodule

// ===== rtl/core/rsd_back.sv =====
// ----------------------------------------------------------------------------
// rsd_back
// Pipelined square root, remap divider and per-axis rescale dividers, with
// the output register at the end. The whole pipe advances as one.
// ----------------------------------------------------------------------------
module rsd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [rsd_pkg::DZ_W-1:0]      deadzone,
	input  logic                          q_not_empty,
	input  rsd_pkg::item_t                q_item,
	output logic                          q_pop,
	output logic                          m_valid,
	input  logic                          m_ready,
	output logic signed [rsd_pkg::AXIS_W-1:0] out_x,
	output logic signed [rsd_pkg::AXIS_W-1:0] out_y,
	output logic                          in_deadzone
);

	localparam int SQ_N    = rsd_pkg::MAG_W;
	localparam int ST_CMP  = SQ_N + 1;
	localparam int ST_MUL  = ST_CMP + 1;
	localparam int ST_OVF  = ST_MUL + 1;
	localparam int ST_NM   = ST_OVF + rsd_pkg::NM_W + 1;
	localparam int ST_PM   = ST_NM + 1;
	localparam int ST_SOV  = ST_PM + 1;
	localparam int ST_OUT  = ST_SOV + rsd_pkg::AX_QW + 1;
	localparam int DEN_W   = rsd_pkg::FULL_W;
	localparam int MW      = rsd_pkg::MAG_W;
	localparam int QW      = rsd_pkg::AX_QW;
	localparam int NW      = rsd_pkg::NM_W;

	logic                 en;
	logic [ST_OUT:0]      v_s;
	rsd_pkg::item_t       pipe_s [0:ST_OUT-1];
	rsd_pkg::late_t       late_s [ST_CMP:ST_OUT-1];
	rsd_pkg::sq_t         sq_s   [1:SQ_N];

	logic [MW-1:0]                diff_s;
	logic [rsd_pkg::NUM_W-1:0]    num_s;
	logic [DEN_W-1:0]             den_s;
	logic [DEN_W-1:0]             dv_rem_s [0:NW-1];
	logic [NW-1:0]                dv_q_s   [0:NW];
	logic [NW-1:0]                dv_lo_s  [0:NW-1];
	logic [DEN_W-1:0]             dv_den_s [0:NW-1];

	logic [rsd_pkg::PROD_W-1:0]   prod_s   [2];
	logic [MW-1:0]                sc_rem_s [2][0:QW-1];
	logic [QW-1:0]                sc_q_s   [2][0:QW];
	logic [QW-1:0]                sc_lo_s  [2][0:QW-1];
	logic                         sc_ovf_s [2][0:QW];
	logic signed [rsd_pkg::AXIS_W-1:0] res_s [2];
	logic                         indz_s;

	logic [MW-1:0]                dz256;
	logic                         dz_sat;

	// one enable for the whole pipe: move when the output is free or taken
	assign en    = !v_s[ST_OUT] || m_ready;
	assign q_pop = q_not_empty && en;
	assign dz256 = MW'({deadzone, 8'h00});
	assign dz_sat = (int'(deadzone) >= rsd_pkg::FULL_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[ST_OUT-1:0], q_pop};
		end
	end

	// carry the item along every stage
	always_ff @(posedge clk) begin
		if (en) pipe_s[0] <= q_item;
	end
	for (genvar i = 1; i < ST_OUT; i++) begin : g_pass
		always_ff @(posedge clk) begin
			if (en) pipe_s[i] <= pipe_s[i-1];
		end
	end

	// square root, one result bit per stage
	for (genvar k = 1; k <= SQ_N; k++) begin : g_sqrt
		logic [rsd_pkg::RAD_W-1:0] rad;
		rsd_pkg::sq_t              prev;
		assign rad = {pipe_s[k-1].sumsq, rsd_pkg::FRAC_SH'(0)};
		if (k == 1) begin : g_first
			assign prev = '0;
		end else begin : g_next
			assign prev = sq_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (en) sq_s[k] <= rsd_pkg::sqrt_step(prev, rad[rsd_pkg::RAD_W-2*k+1 -: 2]);
		end
	end

	// compare with the deadzone radius
	always_ff @(posedge clk) begin
		if (en) begin
			late_s[ST_CMP].mag    <= sq_s[SQ_N].root;
			late_s[ST_CMP].indz   <= !pipe_s[SQ_N].bypass && (sq_s[SQ_N].root < dz256);
			late_s[ST_CMP].sat    <= dz_sat;
			late_s[ST_CMP].ovf    <= 1'b0;
			late_s[ST_CMP].newmag <= '0;
			diff_s                <= sq_s[SQ_N].root - dz256;
		end
	end

	// numerator and divisor of the remap
	always_ff @(posedge clk) begin
		if (en) begin
			num_s <= rsd_pkg::NUM_W'(diff_s) * rsd_pkg::NUM_W'(rsd_pkg::FULL_SCALE);
			den_s <= DEN_W'(rsd_pkg::FULL_SCALE - int'(deadzone));
		end
	end

	// remap divider setup: quotient too wide saturates
	always_ff @(posedge clk) begin
		if (en) begin
			dv_rem_s[0] <= DEN_W'(num_s[rsd_pkg::NUM_W-1:NW]);
			dv_q_s[0]   <= '0;
			dv_lo_s[0]  <= num_s[NW-1:0];
			dv_den_s[0] <= den_s;
		end
	end

	// remap divider, one quotient bit per stage
	for (genvar j = 1; j <= NW; j++) begin : g_div
		logic [DEN_W:0] cur;
		logic           ge;
		assign cur = {dv_rem_s[j-1], dv_lo_s[j-1][NW-j]};
		assign ge  = (cur >= {1'b0, dv_den_s[j-1]});
		always_ff @(posedge clk) begin
			if (en) dv_q_s[j] <= {dv_q_s[j-1][NW-2:0], ge};
		end
		// carry remainder and operands to the next digit
		if (j < NW) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					dv_rem_s[j] <= ge ? DEN_W'(cur - {1'b0, dv_den_s[j-1]}) : DEN_W'(cur);
					dv_lo_s[j]  <= dv_lo_s[j-1];
					dv_den_s[j] <= dv_den_s[j-1];
				end
			end
		end
	end

	// late fields: update at their own stage, otherwise hold along
	for (genvar i = ST_CMP + 1; i < ST_OUT; i++) begin : g_late
		if (i == ST_OVF) begin : g_ovf
			always_ff @(posedge clk) begin
				rsd_pkg::late_t nxt;
				nxt     = late_s[i-1];
				nxt.ovf = late_s[i-1].sat ||
					((rsd_pkg::NUM_W - NW + 1)'(num_s[rsd_pkg::NUM_W-1:NW]) >=
					 (rsd_pkg::NUM_W - NW + 1)'(den_s));
				if (en) late_s[i] <= nxt;
			end
		end else if (i == ST_NM) begin : g_nm
			always_ff @(posedge clk) begin
				rsd_pkg::late_t nxt;
				nxt        = late_s[i-1];
				nxt.newmag = (late_s[i-1].ovf ||
					int'(dv_q_s[NW]) > rsd_pkg::NEWMAG_MAX) ?
					NW'(rsd_pkg::NEWMAG_MAX) : dv_q_s[NW];
				if (en) late_s[i] <= nxt;
			end
		end else begin : g_hold
			always_ff @(posedge clk) begin
				if (en) late_s[i] <= late_s[i-1];
			end
		end
	end

	// per-axis rescale: |axis| * newmag / mag
	for (genvar a = 0; a < 2; a++) begin : g_axis
		logic [rsd_pkg::AXIS_W-1:0] ua;
		logic [NW-1:0]              hi;
		assign ua = (a == 0) ? pipe_s[ST_NM].ux : pipe_s[ST_NM].uy;
		assign hi = prod_s[a][rsd_pkg::PROD_W-1:QW];

		always_ff @(posedge clk) begin
			if (en) prod_s[a] <= rsd_pkg::PROD_W'(ua) * rsd_pkg::PROD_W'(late_s[ST_NM].newmag);
		end

		// setup: quotient at or above 2^15 saturates
		always_ff @(posedge clk) begin
			if (en) begin
				sc_ovf_s[a][0] <= ((MW + 1)'(hi) >= (MW + 1)'(late_s[ST_PM].mag));
				sc_rem_s[a][0] <= MW'(hi);
				sc_q_s[a][0]   <= '0;
				sc_lo_s[a][0]  <= prod_s[a][QW-1:0];
			end
		end

		for (genvar j = 1; j <= QW; j++) begin : g_step
			logic [MW:0] cur;
			logic        ge;
			assign cur = {sc_rem_s[a][j-1], sc_lo_s[a][j-1][QW-j]};
			assign ge  = (cur >= {1'b0, late_s[ST_SOV+j-1].mag});
			always_ff @(posedge clk) begin
				if (en) begin
					sc_q_s[a][j]   <= {sc_q_s[a][j-1][QW-2:0], ge};
					sc_ovf_s[a][j] <= sc_ovf_s[a][j-1];
				end
			end
			// carry remainder and low product bits to the next digit
			if (j < QW) begin : g_carry
				always_ff @(posedge clk) begin
					if (en) begin
						sc_rem_s[a][j] <= ge ? MW'(cur - {1'b0, late_s[ST_SOV+j-1].mag})
						                     : MW'(cur);
						sc_lo_s[a][j]  <= sc_lo_s[a][j-1];
					end
				end
			end
		end

		// saturate, restore the sign, pick bypass or deadzone result
		always_ff @(posedge clk) begin
			logic [QW-1:0]                   q;
			logic                            neg;
			logic signed [rsd_pkg::AXIS_W-1:0] raw;
			raw = (a == 0) ? pipe_s[ST_OUT-1].x : pipe_s[ST_OUT-1].y;
			neg = raw[rsd_pkg::AXIS_W-1];
			q   = sc_q_s[a][QW];
			if (en) begin
				if (pipe_s[ST_OUT-1].bypass) begin
					res_s[a] <= raw;
				end else if (late_s[ST_OUT-1].indz) begin
					res_s[a] <= '0;
				end else if (neg) begin
					if (sc_ovf_s[a][QW] || int'(q) > rsd_pkg::NEG_LIM)
						q = QW'(rsd_pkg::NEG_LIM);
					res_s[a] <= rsd_pkg::AXIS_W'(~q + 1'b1);
				end else begin
					if (sc_ovf_s[a][QW] || int'(q) > rsd_pkg::POS_LIM)
						q = QW'(rsd_pkg::POS_LIM);
					res_s[a] <= rsd_pkg::AXIS_W'(q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) indz_s <= late_s[ST_OUT-1].indz;
	end

	assign m_valid     = v_s[ST_OUT];
	assign out_x       = res_s[0];
	assign out_y       = res_s[1];
	assign in_deadzone = indz_s;

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid && in_deadzone) |-> (out_x == '0 && out_y == '0))
		else $error("deadzone result not zero");
	a_sqrt_exact: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[SQ_N] |->
		((48'(sq_s[SQ_N].root) * 48'(sq_s[SQ_N].root) <=
		  48'({pipe_s[SQ_N].sumsq, rsd_pkg::FRAC_SH'(0)})) &&
		 ((48'(sq_s[SQ_N].root) + 48'd1) * (48'(sq_s[SQ_N].root) + 48'd1) >
		  48'({pipe_s[SQ_N].sumsq, rsd_pkg::FRAC_SH'(0)}))))
		else $error("square root stage wrong");
	a_newmag_cap: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[ST_NM] |-> (int'(late_s[ST_NM].newmag) <= rsd_pkg::NEWMAG_MAX))
		else $error("remapped magnitude above full scale");

endmodule

// ===== rtl/core/radial_stick_deadzone_unit.sv =====
// ----------------------------------------------------------------------------
// radial_stick_deadzone_unit
// Scaled radial deadzone for one analog stick sample stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one stick sample per beat (x, y), m_axis one result per
//   beat (rescaled x, y, and tuser set when the sample fell inside the
//   deadzone and was zeroed). The cfg channel writes the deadzone radius;
//   write it only while no samples are in flight. Zero passes samples through.
//   Throughput is one sample per cycle while m_axis does not stall. From input
//   beat to result beat a sample passes 2 front stages, 1 queue slot, then a
//   68-stage back pipe (23 square root digits, 22 remap quotient bits, 15 axis
//   quotient bits, plus setup and output stages).
//   Reset clears all valid bits and loads a deadzone of 1000.
//   When m_axis stalls, the back pipe freezes as a whole while the front
//   keeps taking beats until the two-entry queue and both front stages
//   fill; s_axis_tready then drops.
// ----------------------------------------------------------------------------
module radial_stick_deadzone_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [rsd_pkg::DATA_W-1:0]  s_axis_tdata,   // stick_x[14:0], stick_y[29:15]
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [rsd_pkg::DATA_W-1:0]  m_axis_tdata,   // out_x[14:0], out_y[29:15]
	output logic                        m_axis_tuser,   // in_deadzone
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [rsd_pkg::DZ_W-1:0]    cfg_data        // deadzone
);

	logic [rsd_pkg::DZ_W-1:0]          deadzone_q;
	logic                              q_full, q_push, q_pop, q_not_empty;
	rsd_pkg::item_t                    push_item, pop_item;
	logic signed [rsd_pkg::AXIS_W-1:0] out_x, out_y;

	// deadzone register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q <= rsd_pkg::DZ_W'(rsd_pkg::DZ_RESET);
		end else if (cfg_valid) begin
			deadzone_q <= cfg_data;
		end
	end

	rsd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.deadzone      (deadzone_q),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (push_item)
	);

	rsd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_item   (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rd_item   (pop_item)
	);

	rsd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.deadzone    (deadzone_q),
		.q_not_empty (q_not_empty),
		.q_item      (pop_item),
		.q_pop       (q_pop),
		.m_valid     (m_axis_tvalid),
		.m_ready     (m_axis_tready),
		.out_x       (out_x),
		.out_y       (out_y),
		.in_deadzone (m_axis_tuser)
	);

	assign m_axis_tdata = {(rsd_pkg::DATA_W - 2*rsd_pkg::AXIS_W)'(0), out_y, out_x};

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stream test of radial_stick_deadzone_unit. Each accepted stick sample is
// run through an in-bench fixed-point deadzone predictor. Each result beat is
// checked field by field against the oldest prediction. The deadzone register
// is rewritten between phases while the unit is idle. Both sides stall in
// random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct packed {
		logic signed [rsd_pkg::AXIS_W-1:0] x;
		logic signed [rsd_pkg::AXIS_W-1:0] y;
	} sample_t;

	typedef struct packed {
		logic signed [rsd_pkg::AXIS_W-1:0] x;
		logic signed [rsd_pkg::AXIS_W-1:0] y;
		logic                              zeroed;
	} shaped_t;

	localparam int DRAIN_CYC = 90;
	localparam int CYC_LIMIT = 600000;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_axis_tvalid = 1'b0;
	logic                         s_axis_tready;
	logic [rsd_pkg::DATA_W-1:0]   s_axis_tdata = '0;
	logic                         m_axis_tvalid;
	logic                         m_axis_tready = 1'b0;
	logic [rsd_pkg::DATA_W-1:0]   m_axis_tdata;
	logic                         m_axis_tuser;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [rsd_pkg::DZ_W-1:0]     cfg_data = '0;

	sample_t    pending_samples[$];
	shaped_t    expected_shapes[$];
	logic [rsd_pkg::DZ_W-1:0] dz_radius = rsd_pkg::DZ_W'(rsd_pkg::DZ_RESET);
	logic       in_beat = 1'b0;
	logic       quiet = 1'b0;
	int         src_gap = 0;
	int         snk_gap = 0;
	int         cycles = 0;
	int         errors = 0;

	radial_stick_deadzone_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// integer square root, floor
	function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
		logic [63:0] root;
		logic [63:0] bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// scale one axis by newmag/mag, truncate toward zero, saturate to 15 bits
	function automatic logic signed [rsd_pkg::AXIS_W-1:0] rescale_axis(
			input logic signed [rsd_pkg::AXIS_W-1:0] a,
			input logic [63:0] newmag, input logic [63:0] mag);
		logic [63:0] ua;
		logic [63:0] q;
		ua = a < 0 ? 64'(-64'(a)) : 64'(a);
		q  = ua * newmag / mag;
		if (a < 0) begin
			if (q > 64'(rsd_pkg::NEG_LIM)) q = 64'(rsd_pkg::NEG_LIM);
			return rsd_pkg::AXIS_W'(-q);
		end
		if (q > 64'(rsd_pkg::POS_LIM)) q = 64'(rsd_pkg::POS_LIM);
		return rsd_pkg::AXIS_W'(q);
	endfunction

	function automatic shaped_t shape_sample(input sample_t s,
			input logic [rsd_pkg::DZ_W-1:0] dz);
		shaped_t     r;
		logic [63:0] ux;
		logic [63:0] uy;
		logic [63:0] mag;
		logic [63:0] dz256;
		logic [63:0] newmag;
		logic [63:0] remap;
		r = '0;
		if (dz == 0) begin
			r.x = s.x;
			r.y = s.y;
			return r;
		end
		ux = s.x < 0 ? 64'(-64'(s.x)) : 64'(s.x);
		uy = s.y < 0 ? 64'(-64'(s.y)) : 64'(s.y);
		mag = floor_sqrt((ux * ux + uy * uy) << 16);
		dz256 = 64'(dz) << 8;
		if (mag < dz256) begin
			r.zeroed = 1'b1;
			return r;
		end
		newmag = 64'(rsd_pkg::FULL_SCALE) << 8;
		if (dz < rsd_pkg::FULL_SCALE) begin
			remap = (mag - dz256) * 64'(rsd_pkg::FULL_SCALE)
			      / (64'(rsd_pkg::FULL_SCALE) - 64'(dz));
			if (remap < newmag) newmag = remap;
		end
		r.x = rescale_axis(s.x, newmag, mag);
		r.y = rescale_axis(s.y, newmag, mag);
		return r;
	endfunction

	// drive sample beats: hold until taken, then gap or advance
	always @(negedge clk) begin
		logic    nv;
		sample_t nxt;
		nv = s_axis_tvalid;
		if (!(s_axis_tvalid && !in_beat)) begin
			nv = 1'b0;
			if (src_gap > 0) begin
				src_gap = src_gap - 1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				src_gap = $urandom_range(1, 18) - 1;
			end else if (pending_samples.size() > 0 && arst_n) begin
				nxt = pending_samples.pop_front();
				nv = 1'b1;
				s_axis_tdata <= {2'b00, nxt.y, nxt.x};
			end
		end
		s_axis_tvalid <= nv;
	end

	// sink stalls
	always @(negedge clk) begin
		if (snk_gap > 0) begin
			snk_gap = snk_gap - 1;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			snk_gap = $urandom_range(1, 18) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// monitor: predict on sample beats, check result beats
	always @(posedge clk) begin
		sample_t s;
		shaped_t want;
		in_beat <= s_axis_tvalid && s_axis_tready;
		if (cfg_valid && cfg_ready) dz_radius <= cfg_data;
		if (s_axis_tvalid && s_axis_tready) begin
			s.x = s_axis_tdata[rsd_pkg::AXIS_W-1:0];
			s.y = s_axis_tdata[2*rsd_pkg::AXIS_W-1:rsd_pkg::AXIS_W];
			expected_shapes.push_back(shape_sample(s, dz_radius));
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_shapes.size() == 0) begin
				$display("%0t: unexpected result beat x=%0d y=%0d zeroed=%0b", $time,
					$signed(m_axis_tdata[rsd_pkg::AXIS_W-1:0]),
					$signed(m_axis_tdata[2*rsd_pkg::AXIS_W-1:rsd_pkg::AXIS_W]),
					m_axis_tuser);
				errors = errors + 1;
			end else begin
				want = expected_shapes.pop_front();
				if (m_axis_tdata[rsd_pkg::AXIS_W-1:0] !== want.x) begin
					$display("%0t: out_x expected %0d actual %0d", $time, want.x,
						$signed(m_axis_tdata[rsd_pkg::AXIS_W-1:0]));
					errors = errors + 1;
				end
				if (m_axis_tdata[2*rsd_pkg::AXIS_W-1:rsd_pkg::AXIS_W] !== want.y) begin
					$display("%0t: out_y expected %0d actual %0d", $time, want.y,
						$signed(m_axis_tdata[2*rsd_pkg::AXIS_W-1:rsd_pkg::AXIS_W]));
					errors = errors + 1;
				end
				if (m_axis_tuser !== want.zeroed) begin
					$display("%0t: in_deadzone expected %0b actual %0b", $time,
						want.zeroed, m_axis_tuser);
					errors = errors + 1;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles > CYC_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_samples.size() != 0 || expected_shapes.size() != 0 || s_axis_tvalid);
		repeat (DRAIN_CYC) @(negedge clk);
	endtask

	task automatic write_radius(input logic [rsd_pkg::DZ_W-1:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_xy(input int x, input int y);
		sample_t s;
		s.x = rsd_pkg::AXIS_W'(x);
		s.y = rsd_pkg::AXIS_W'(y);
		pending_samples.push_back(s);
	endtask

	// random samples, mostly in range, some near the radius, some any pattern
	task automatic push_random(input int count, input int radius);
		int sel;
		int r;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 9);
			if (sel < 6) begin
				push_xy($urandom_range(0, 20000) - 10000, $urandom_range(0, 20000) - 10000);
			end else if (sel < 8) begin
				r = radius + $urandom_range(0, 6) - 3;
				if ($urandom_range(0, 1)) push_xy($urandom_range(0, 1) ? r : -r,
						$urandom_range(0, 4) - 2);
				else push_xy($urandom_range(0, 2 * radius + 4) - radius - 2,
						$urandom_range(0, 2 * radius + 4) - radius - 2);
			end else begin
				push_xy($signed(rsd_pkg::AXIS_W'($urandom)),
					$signed(rsd_pkg::AXIS_W'($urandom)));
			end
		end
	endtask

	task automatic push_directed(input int radius);
		push_xy(0, 0);
		push_xy(rsd_pkg::FULL_SCALE, 0);
		push_xy(-rsd_pkg::FULL_SCALE, 0);
		push_xy(0, -rsd_pkg::FULL_SCALE);
		push_xy(rsd_pkg::FULL_SCALE, rsd_pkg::FULL_SCALE);
		push_xy(-rsd_pkg::FULL_SCALE, rsd_pkg::FULL_SCALE);
		push_xy(-16384, -16384);
		push_xy(16383, 16383);
		push_xy(16383, -16384);
		push_xy(-16384, 0);
		push_xy(1, -1);
		push_xy(radius, 0);
		push_xy(radius - 1, 0);
		push_xy(0, -radius);
		push_xy(radius * 3 / 5, radius * 4 / 5);
		push_xy(-7071, 7071);
	endtask

	initial begin
		int radii[5];
		radii = '{0, 9999, 16383, 1, 0};
		radii[4] = $urandom_range(2, 9998);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// reset radius
		push_directed(rsd_pkg::DZ_RESET);
		push_random(220, rsd_pkg::DZ_RESET);
		for (int p = 0; p < 5; p++) begin
			write_radius(rsd_pkg::DZ_W'(radii[p]));
			if (p == 4) quiet = 1'b1;
			push_directed(radii[p]);
			push_random(p == 4 ? 180 : 220, radii[p] > 20000 ? 20000 : radii[p]);
		end
		wait_idle();
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/rsd_pkg.sv
rtl/core/rsd_front.sv
rtl/core/rsd_queue.sv
rtl/core/rsd_back.sv
rtl/core/radial_stick_deadzone_unit.sv
dv/testbench.sv
